// ----- design/svm_pkg.sv -----
// Shared types and codes of the stack VM instruction execute core.
`timescale 1ns / 1ps

package svm_pkg;

  // instruction codes
  localparam logic [3:0] FN_PUSH   = 4'd0;
  localparam logic [3:0] FN_POP    = 4'd1;
  localparam logic [3:0] FN_ADD    = 4'd2;
  localparam logic [3:0] FN_SUB    = 4'd3;
  localparam logic [3:0] FN_NEG    = 4'd4;
  localparam logic [3:0] FN_AND    = 4'd5;
  localparam logic [3:0] FN_OR     = 4'd6;
  localparam logic [3:0] FN_NOT    = 4'd7;
  localparam logic [3:0] FN_EQ     = 4'd8;
  localparam logic [3:0] FN_LT     = 4'd9;
  localparam logic [3:0] FN_GT     = 4'd10;
  localparam logic [3:0] FN_GOTO   = 4'd11;
  localparam logic [3:0] FN_IFGOTO = 4'd12;
  localparam logic [3:0] FN_CALL   = 4'd13;
  localparam logic [3:0] FN_RET    = 4'd14;

  // segment codes
  localparam logic [2:0] SEG_ARG     = 3'd0;
  localparam logic [2:0] SEG_LOCAL   = 3'd1;
  localparam logic [2:0] SEG_STATIC  = 3'd2;
  localparam logic [2:0] SEG_CONST   = 3'd3;
  localparam logic [2:0] SEG_THIS    = 3'd4;
  localparam logic [2:0] SEG_THAT    = 3'd5;
  localparam logic [2:0] SEG_POINTER = 3'd6;
  localparam logic [2:0] SEG_TEMP    = 3'd7;

  // status codes
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_UNDER    = 4'd1;
  localparam logic [3:0] ST_SEG      = 4'd2;
  localparam logic [3:0] ST_STADDR   = 4'd3;
  localparam logic [3:0] ST_HEAP     = 4'd4;
  localparam logic [3:0] ST_PTR      = 4'd5;
  localparam logic [3:0] ST_ADDOVF   = 4'd6;
  localparam logic [3:0] ST_SUBUNF   = 4'd7;
  localparam logic [3:0] ST_ARGS     = 4'd8;
  localparam logic [3:0] ST_NOTARGET = 4'd9;
  localparam logic [3:0] ST_BADOP    = 4'd10;
  localparam logic [3:0] ST_FULL     = 4'd11;
  localparam logic [3:0] ST_HALTED   = 4'd12;

  localparam logic [15:0] TRUE_WORD   = 16'hFFFF;
  localparam int          FRAME_WORDS = 8;

  typedef struct packed {
    logic [3:0]  func;
    logic [2:0]  segment;
    logic [15:0] offset;
    logic [15:0] cur_index;
    logic [3:0]  cur_file;
    logic        target_found;
    logic [15:0] target_index;
    logic [3:0]  target_file;
    logic [15:0] arg_count;
    logic [15:0] local_count;
  } instr_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] top_value;
    logic        jump_taken;
    logic [15:0] next_index;
    logic [3:0]  next_file;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic clear;
    logic rd;
    logic exec;
    logic frame_push;
    logic local_push;
    logic ret_step;
    logic top_rd;
    logic top_cap;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic go_call;
    logic go_ret;
    logic frame_last;
    logic locals_zero;
    logic ret_last;
  } sts_t;

endpackage

// ----- design/svm_ctrl.sv -----
// Sequencing state machine of the stack VM instruction execute core.
`timescale 1ns / 1ps

module svm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          instr_valid,
  output logic          instr_ready,
  output logic          result_valid,
  input  logic          result_ready,
  output svm_pkg::cmd_t cmd,
  input  svm_pkg::sts_t sts
);
  import svm_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_EXEC, S_FRAME, S_LOCALS, S_RET, S_TOPRD, S_TOPCAP, S_OUT
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign instr_ready = (state == S_IDLE);
  assign out_free    = !result_valid || result_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.load_in = instr_valid;
        if (instr_valid) state_next = S_READ;
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.go_call)     state_next = S_FRAME;
        else if (sts.go_ret) state_next = S_RET;
        else                 state_next = S_TOPRD;
      end
      S_FRAME: begin
        cmd.frame_push = 1'b1;
        if (sts.frame_last) state_next = S_LOCALS;
      end
      S_LOCALS: begin
        if (sts.locals_zero) state_next = S_TOPRD;
        else                 cmd.local_push = 1'b1;
      end
      S_RET: begin
        cmd.ret_step = 1'b1;
        if (sts.ret_last) state_next = S_TOPRD;
      end
      S_TOPRD: begin
        cmd.top_rd = 1'b1;
        state_next = S_TOPCAP;
      end
      S_TOPCAP: begin
        cmd.top_cap = 1'b1;
        state_next  = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out)   result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

endmodule

// ----- design/svm_dpath.sv -----
// Datapath of the stack VM core: machine registers, memories and execute checks.
`timescale 1ns / 1ps

module svm_dpath #(
  parameter int STACK_DEPTH  = 1024,
  parameter int HEAP_WORDS   = 16384,
  parameter int STATIC_WORDS = 240,
  parameter int TEMP_WORDS   = 8,
  parameter int FILE_COUNT   = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  svm_pkg::cmd_t    cmd,
  output svm_pkg::sts_t    sts,
  input  svm_pkg::instr_t  instr,
  output svm_pkg::result_t result
);
  import svm_pkg::*;

  localparam int SAW     = $clog2(STACK_DEPTH);
  localparam int SPW     = $clog2(STACK_DEPTH + 1);
  localparam int HAW     = $clog2(HEAP_WORDS);
  localparam int SDEPTH  = FILE_COUNT * STATIC_WORDS;
  localparam int TDEPTH  = FILE_COUNT * TEMP_WORDS;
  localparam int STW     = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int TPW     = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
  localparam int BKW     = (FILE_COUNT > 1) ? $clog2(FILE_COUNT) : 1;
  localparam int CLR_A   = (HEAP_WORDS > SDEPTH) ? HEAP_WORDS : SDEPTH;
  localparam int CLR_LEN = (CLR_A > TDEPTH) ? CLR_A : TDEPTH;
  localparam int CLW     = $clog2(CLR_LEN + 1);

  // machine state
  instr_t          ir;
  logic [SPW-1:0]  sp;
  logic [15:0]     arg_base, arg_length, local_base, local_length;
  logic [15:0]     this_base, that_base;
  logic            halted;
  logic [15:0]     top_word;

  // sequencing registers
  logic [SPW-1:0]  call_sp;
  logic [2:0]      frame_cnt;
  logic [15:0]     local_cnt;
  logic [1:0]      ret_cnt;
  logic [15:0]     fr;
  logic [CLW-1:0]  clr_cnt;
  logic [3:0]      res_status;
  logic            res_jump;
  logic [15:0]     res_ni;
  logic [3:0]      res_nf;

  // memories
  logic [15:0] stack_mem  [STACK_DEPTH];
  logic [15:0] heap_mem   [HEAP_WORDS];
  logic [15:0] static_mem [SDEPTH];
  logic [15:0] temp_mem   [TDEPTH];
  logic [15:0] qa, qb, heap_q, static_q, temp_q;

  // file bank lookup
  logic [BKW-1:0] bank_lut [16];
  logic [BKW-1:0] bank;
  for (genvar i = 0; i < 16; i++) begin : g_bank
    assign bank_lut[i] = BKW'(i % FILE_COUNT);
  end
  assign bank = bank_lut[ir.cur_file];

  logic [16:0]    sp17, seg_ea, heap_ea, addr_a, addr_b;
  logic [STW-1:0] static_idx;
  logic [TPW-1:0] temp_idx;
  logic           full;

  assign sp17       = 17'(sp);
  assign full       = (sp17 >= 17'(STACK_DEPTH));
  assign seg_ea     = {1'b0, (ir.segment == SEG_ARG) ? arg_base : local_base}
                    + {1'b0, ir.offset};
  assign heap_ea    = {1'b0, (ir.segment == SEG_THIS) ? this_base : that_base}
                    + {1'b0, ir.offset};
  assign static_idx = STW'(int'(bank) * STATIC_WORDS) + STW'(ir.offset);
  assign temp_idx   = TPW'(int'(bank) * TEMP_WORDS) + TPW'(ir.offset);

  // stack read addresses
  always_comb begin
    addr_a = sp17 - 17'd1;
    addr_b = seg_ea;
    if (cmd.rd) begin
      if (ir.func == FN_RET) begin
        addr_a = {1'b0, local_base - 16'd8};
        addr_b = {1'b0, local_base - 16'd7};
      end else begin
        addr_a = sp17 - 17'd2;
      end
    end else if (cmd.ret_step) begin
      addr_a = {1'b0, fr - {13'b0, ret_cnt, 1'b1}};
      addr_b = {1'b0, fr - {13'b0, ret_cnt, 1'b0} - 16'd2};
    end
  end

  // execute: checks and effects of one instruction
  logic [3:0]     e_status;
  logic           e_jump, e_we, e_heap_we, e_static_we, e_temp_we;
  logic           e_this_we, e_that_we, e_call, e_ret, e_ok;
  logic [15:0]    e_ni, e_wdata, alu_r, x, y;
  logic [3:0]     e_nf;
  logic [16:0]    e_waddr, sum;
  logic [SPW-1:0] e_sp;
  logic           need1;
  logic [17:0]    call_end, cab_w, clb_w;

  assign x        = qa;
  assign y        = top_word;
  assign sum      = {1'b0, x} + {1'b0, y};
  assign need1    = (ir.func == FN_NEG) || (ir.func == FN_NOT);
  assign call_end = 18'(sp) + 18'(FRAME_WORDS) + 18'(ir.local_count);
  assign cab_w    = 18'(call_sp) - 18'(ir.arg_count);
  assign clb_w    = 18'(call_sp) + 18'(FRAME_WORDS);

  always_comb begin
    e_status    = ST_OK;
    e_jump      = 1'b0;
    e_ni        = ir.cur_index + 16'd1;
    e_nf        = ir.cur_file;
    e_sp        = sp;
    e_we        = 1'b0;
    e_waddr     = sp17;
    e_wdata     = '0;
    e_heap_we   = 1'b0;
    e_static_we = 1'b0;
    e_temp_we   = 1'b0;
    e_this_we   = 1'b0;
    e_that_we   = 1'b0;
    e_call      = 1'b0;
    e_ret       = 1'b0;
    alu_r       = '0;
    if (halted) begin
      e_status = ST_HALTED;
    end else begin
      unique case (ir.func) inside
        FN_PUSH, FN_POP: begin
          unique case (ir.segment)
            SEG_ARG, SEG_LOCAL: begin
              if (ir.offset >= ((ir.segment == SEG_ARG) ? arg_length : local_length))
                e_status = ST_SEG;
              else if (seg_ea >= sp17) e_status = ST_STADDR;
              else if (ir.func == FN_POP) begin
                e_we = 1'b1; e_waddr = seg_ea; e_wdata = y; e_sp = sp - SPW'(1);
              end else if (full) e_status = ST_FULL;
              else begin
                e_we = 1'b1; e_wdata = qb; e_sp = sp + SPW'(1);
              end
            end
            SEG_STATIC, SEG_TEMP: begin
              if (17'(ir.offset) >= ((ir.segment == SEG_STATIC) ? 17'(STATIC_WORDS)
                                                                : 17'(TEMP_WORDS)))
                e_status = ST_SEG;
              else if (ir.func == FN_POP) begin
                if (sp == '0) e_status = ST_UNDER;
                else begin
                  e_static_we = (ir.segment == SEG_STATIC);
                  e_temp_we   = (ir.segment == SEG_TEMP);
                  e_sp        = sp - SPW'(1);
                end
              end else if (full) e_status = ST_FULL;
              else begin
                e_we    = 1'b1;
                e_wdata = (ir.segment == SEG_STATIC) ? static_q : temp_q;
                e_sp    = sp + SPW'(1);
              end
            end
            SEG_CONST: begin
              if (ir.func == FN_POP) begin
                if (sp == '0) e_status = ST_UNDER;
                else e_sp = sp - SPW'(1);
              end else if (full) e_status = ST_FULL;
              else begin
                e_we = 1'b1; e_wdata = ir.offset; e_sp = sp + SPW'(1);
              end
            end
            SEG_THIS, SEG_THAT: begin
              if (heap_ea >= 17'(HEAP_WORDS)) e_status = ST_HEAP;
              else if (ir.func == FN_POP) begin
                if (sp == '0) e_status = ST_UNDER;
                else begin
                  e_heap_we = 1'b1; e_sp = sp - SPW'(1);
                end
              end else if (full) e_status = ST_FULL;
              else begin
                e_we = 1'b1; e_wdata = heap_q; e_sp = sp + SPW'(1);
              end
            end
            default: begin
              if (ir.offset > 16'd1) e_status = ST_PTR;
              else if (ir.func == FN_POP) begin
                if (sp == '0) e_status = ST_UNDER;
                else begin
                  e_this_we = (ir.offset == 16'd0);
                  e_that_we = (ir.offset != 16'd0);
                  e_sp      = sp - SPW'(1);
                end
              end else if (full) e_status = ST_FULL;
              else begin
                e_we    = 1'b1;
                e_wdata = (ir.offset == 16'd0) ? this_base : that_base;
                e_sp    = sp + SPW'(1);
              end
            end
          endcase
        end
        [FN_ADD:FN_GT]: begin
          if (sp17 < (need1 ? 17'd1 : 17'd2)) begin
            e_status = ST_UNDER;
          end else begin
            unique case (ir.func)
              FN_ADD: begin
                alu_r = sum[15:0];
                if (sum[16]) e_status = ST_ADDOVF;
              end
              FN_SUB: begin
                alu_r = x - y;
                if (x < y) e_status = ST_SUBUNF;
              end
              FN_NEG:  alu_r = 16'h0 - y;
              FN_AND:  alu_r = x & y;
              FN_OR:   alu_r = x | y;
              FN_NOT:  alu_r = ~y;
              FN_EQ:   alu_r = (x == y) ? TRUE_WORD : 16'h0;
              FN_LT:   alu_r = (x < y) ? TRUE_WORD : 16'h0;
              default: alu_r = (x > y) ? TRUE_WORD : 16'h0;
            endcase
            e_we    = 1'b1;
            e_waddr = sp17 - (need1 ? 17'd1 : 17'd2);
            e_wdata = alu_r;
            e_sp    = need1 ? sp : sp - SPW'(1);
          end
        end
        FN_GOTO: begin
          if (!ir.target_found) e_status = ST_NOTARGET;
          else begin
            e_jump = 1'b1; e_ni = ir.target_index; e_nf = ir.target_file;
          end
        end
        FN_IFGOTO: begin
          if (sp == '0) e_status = ST_UNDER;
          else if (y != 16'h0) begin
            if (!ir.target_found) e_status = ST_NOTARGET;
            else begin
              e_sp = sp - SPW'(1); e_jump = 1'b1;
              e_ni = ir.target_index; e_nf = ir.target_file;
            end
          end else begin
            e_sp = sp - SPW'(1);
          end
        end
        FN_CALL: begin
          if (18'(ir.arg_count) > 18'(sp)) e_status = ST_ARGS;
          else if (!ir.target_found) e_status = ST_NOTARGET;
          else if (call_end > 18'(STACK_DEPTH)) e_status = ST_FULL;
          else begin
            e_call = 1'b1; e_jump = 1'b1;
            e_ni = ir.target_index; e_nf = ir.target_file;
          end
        end
        FN_RET: begin
          if (sp == '0) e_status = ST_UNDER;
          else if ((local_base < 16'(FRAME_WORDS)) || (18'(local_base) > 18'(sp))
                   || (18'(arg_base) >= 18'(sp)))
            e_status = ST_STADDR;
          else begin
            e_ret   = 1'b1; e_jump = 1'b1;
            e_we    = 1'b1; e_waddr = {1'b0, arg_base}; e_wdata = y;
            e_sp    = SPW'(17'(arg_base) + 17'd1);
            e_ni    = qa + 16'd1;
            e_nf    = qb[3:0];
          end
        end
        default: e_status = ST_BADOP;
      endcase
    end
    e_ok = (e_status == ST_OK);
    if (!e_ok) begin
      e_jump = 1'b0;
      e_ni   = ir.cur_index;
      e_nf   = ir.cur_file;
    end
  end

  // stack write port
  logic           st_we;
  logic [SAW-1:0] st_waddr;
  logic [15:0]    st_wdata, frame_word;

  always_comb begin
    case (frame_cnt)
      3'd0:    frame_word = ir.cur_index;
      3'd1:    frame_word = {12'b0, ir.cur_file};
      3'd2:    frame_word = local_base;
      3'd3:    frame_word = local_length;
      3'd4:    frame_word = arg_base;
      3'd5:    frame_word = arg_length;
      3'd6:    frame_word = this_base;
      default: frame_word = that_base;
    endcase
  end

  always_comb begin
    st_we    = 1'b0;
    st_waddr = sp[SAW-1:0];
    st_wdata = '0;
    if (cmd.exec && e_ok && e_we) begin
      st_we    = 1'b1;
      st_waddr = e_waddr[SAW-1:0];
      st_wdata = e_wdata;
    end else if (cmd.frame_push) begin
      st_we    = 1'b1;
      st_wdata = frame_word;
    end else if (cmd.local_push && (local_cnt != 16'd0)) begin
      st_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) stack_mem[st_waddr] <= st_wdata;
    qa <= stack_mem[addr_a[SAW-1:0]];
    qb <= stack_mem[addr_b[SAW-1:0]];
  end

  // heap, static and temp memories with a shared clearing pass
  always_ff @(posedge clk) begin
    if (cmd.clear && (32'(clr_cnt) < HEAP_WORDS))
      heap_mem[clr_cnt[HAW-1:0]] <= '0;
    else if (cmd.exec && e_ok && e_heap_we)
      heap_mem[heap_ea[HAW-1:0]] <= top_word;
    heap_q <= heap_mem[heap_ea[HAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear && (32'(clr_cnt) < SDEPTH))
      static_mem[clr_cnt[STW-1:0]] <= '0;
    else if (cmd.exec && e_ok && e_static_we)
      static_mem[static_idx] <= top_word;
    static_q <= static_mem[static_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear && (32'(clr_cnt) < TDEPTH))
      temp_mem[clr_cnt[TPW-1:0]] <= '0;
    else if (cmd.exec && e_ok && e_temp_we)
      temp_mem[temp_idx] <= top_word;
    temp_q <= temp_mem[temp_idx];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sp           <= '0;
      arg_base     <= '0;
      arg_length   <= '0;
      local_base   <= '0;
      local_length <= '0;
      this_base    <= '0;
      that_base    <= '0;
      halted       <= 1'b0;
      frame_cnt    <= '0;
      ret_cnt      <= '0;
      clr_cnt      <= '0;
    end else begin
      if (cmd.clear) clr_cnt <= clr_cnt + CLW'(1);
      if (cmd.exec) begin
        frame_cnt <= '0;
        ret_cnt   <= '0;
        if (e_ok) begin
          sp <= e_sp;
          if (e_this_we) this_base <= top_word;
          if (e_that_we) that_base <= top_word;
        end else if (e_status != ST_HALTED) begin
          halted <= 1'b1;
        end
      end
      if (cmd.frame_push) begin
        sp        <= sp + SPW'(1);
        frame_cnt <= frame_cnt + 3'd1;
        if (frame_cnt == 3'd7) begin
          arg_base     <= cab_w[15:0];
          arg_length   <= ir.arg_count;
          local_base   <= clb_w[15:0];
          local_length <= ir.local_count;
        end
      end
      if (cmd.local_push && (local_cnt != 16'd0)) sp <= sp + SPW'(1);
      if (cmd.ret_step) begin
        ret_cnt <= ret_cnt + 2'd1;
        case (ret_cnt)
          2'd1: begin
            that_base <= qa;
            this_base <= qb;
          end
          2'd2: begin
            arg_length <= qa;
            arg_base   <= qb;
          end
          2'd3: begin
            local_length <= qa;
            local_base   <= qb;
          end
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) ir <= instr;
    if (cmd.exec) begin
      res_status <= e_status;
      res_jump   <= e_jump;
      res_ni     <= e_ni;
      res_nf     <= e_nf;
      fr         <= local_base;
      call_sp    <= sp;
      local_cnt  <= ir.local_count;
    end
    if (cmd.local_push && (local_cnt != 16'd0)) local_cnt <= local_cnt - 16'd1;
    if (cmd.top_cap) top_word <= (sp != '0) ? qa : 16'h0;
    if (cmd.load_out) begin
      result.status     <= res_status;
      result.top_value  <= top_word;
      result.jump_taken <= res_jump;
      result.next_index <= res_ni;
      result.next_file  <= res_nf;
    end
  end

  assign sts.clear_done  = (clr_cnt == CLW'(CLR_LEN - 1));
  assign sts.go_call     = e_call && e_ok;
  assign sts.go_ret      = e_ret && e_ok;
  assign sts.frame_last  = (frame_cnt == 3'd7);
  assign sts.locals_zero = (local_cnt == 16'd0);
  assign sts.ret_last    = (ret_cnt == 2'd3);

endmodule

// ----- design/stack_vm_instruction_execute_core.sv -----
// Top level of the stack VM instruction execute core.
`timescale 1ns / 1ps

// Executes one stack VM instruction per instr transaction and returns one
// result transaction for it (status, top of stack, next instruction).
// Channels: instr_valid/instr_ready/instr in, result_valid/result_ready/result
// out, both valid/ready; a transaction moves when valid and ready are high.
// Sequence: an ordinary instruction passes through the read, execute,
// top-of-stack read and capture states into the output register, and the
// next instruction is taken only after its result is loaded. The stack
// memory has one write port, so call pushes its frame words and then its
// locals, one word per cycle, and ret restores the saved frame, reading two
// saved frame words per cycle.
// Reset: rst is synchronous. After it the core sweeps heap, static and temp
// memories to zero, sweeping max(HEAP_WORDS, FILE_COUNT*STATIC_WORDS,
// FILE_COUNT*TEMP_WORDS) addresses (16384 by default), with instr_ready low.
// Stall: a finished result waits in the output register; the core takes the
// next instruction meanwhile and holds its own result until the slot frees.
// After the first error every later result reports the halted status.
module stack_vm_instruction_execute_core #(
  parameter int STACK_DEPTH  = 1024,
  parameter int HEAP_WORDS   = 16384,
  parameter int STATIC_WORDS = 240,
  parameter int TEMP_WORDS   = 8,
  parameter int FILE_COUNT   = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             instr_valid,
  output logic             instr_ready,
  input  svm_pkg::instr_t  instr,
  output logic             result_valid,
  input  logic             result_ready,
  output svm_pkg::result_t result
);
  import svm_pkg::*;

  cmd_t cmd;  // sequencer commands
  sts_t sts;  // datapath status back to the sequencer

  svm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .instr_valid  (instr_valid),
    .instr_ready  (instr_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  // machine registers, memories and the execute checks live here
  svm_dpath #(
    .STACK_DEPTH  (STACK_DEPTH),
    .HEAP_WORDS   (HEAP_WORDS),
    .STATIC_WORDS (STATIC_WORDS),
    .TEMP_WORDS   (TEMP_WORDS),
    .FILE_COUNT   (FILE_COUNT)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .instr  (instr),
    .result (result)
  );

endmodule

// ----- design/svm_checker.sv -----
// Port-level assertion checker for the stack VM core, with its bind.
`timescale 1ns / 1ps

module svm_checker (
  input logic             clk,
  input logic             rst,
  input logic             instr_valid,
  input logic             instr_ready,
  input logic             result_valid,
  input logic             result_ready,
  input svm_pkg::result_t result
);
  import svm_pkg::*;

  logic [1:0] pending;
  logic       seen_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= '0;
      seen_err <= 1'b0;
    end else begin
      pending <= pending + 2'((instr_valid && instr_ready) ? 1 : 0)
                         - 2'((result_valid && result_ready) ? 1 : 0);
      if (result_valid && result_ready && (result.status != ST_OK)
          && (result.status != ST_HALTED))
        seen_err <= 1'b1;
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(result))
    else $error("result changed while stalled");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pending != 2'd0)
    else $error("result without an instruction");

  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    instr_ready |-> pending <= 2'd1)
    else $error("instruction taken with two outstanding");

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    result_valid && seen_err |-> result.status == ST_HALTED)
    else $error("result after an error is not halted");

endmodule

bind stack_vm_instruction_execute_core svm_checker u_svm_checker (.*);
